// ----- rtl/core/world_aabb_of_transformed_box_top_macros.svh -----
// ---------------------------------------------------------------------------
// world_aabb_of_transformed_box_top_macros
// Assertion macros for the world bound block; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef WORLD_AABB_OF_TRANSFORMED_BOX_TOP_MACROS_SVH
`define WORLD_AABB_OF_TRANSFORMED_BOX_TOP_MACROS_SVH

`ifndef SYNTH
`define WABOX_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wabox assertion failed");
`define WABOX_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wabox assertion failed");
`else
`define WABOX_ASSERT_IMP(label, clk, rst, ante, cons)
`define WABOX_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/wabox_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wabox_pkg
// Widths and shared types of the world bound block.
// ---------------------------------------------------------------------------
package wabox_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_COLS  = 4;
  localparam int ENT_W     = 16;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 48;
  localparam int ACC_W     = 49;
  localparam int MAG_W     = 48;
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = 31;
  localparam int PRE_SHIFT = QUO_W - FRAC_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int CFG_IDX_W = 3;
  localparam int ROW_W     = 64;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic wz;
  } ctl_t;

endpackage

// ----- rtl/core/world_aabb_of_transformed_box_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// world_aabb_of_transformed_box_top
// World axis-aligned bound of the configured local box under a 4x4
// Q8.8 transform, with perspective divide and saturation.
// ---------------------------------------------------------------------------
// Channel   Handshake                   Beat
// item      item_valid / item_stall     matrix_row0..matrix_row3
// result    result_valid / result_stall world_min_*, world_max_*, w_zero
// config    cfg_write_en                cfg_index, cfg_data
//
// One corner enters the transform pipe per cycle while no result stall holds it,
// and the next item is taken while the last corner issues.
// Most of the path from accept to result is the 33 register
// stages of the quotient pipe.
// Reset clears valid bits, the corner sequencer and the box registers.
// A stalled result freezes the whole pipe; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "world_aabb_of_transformed_box_top_macros.svh"

module world_aabb_of_transformed_box_top import wabox_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COORD_W-1:0]         cfg_data,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [ROW_W-1:0]           matrix_row0,
  input  logic [ROW_W-1:0]           matrix_row1,
  input  logic [ROW_W-1:0]           matrix_row2,
  input  logic [ROW_W-1:0]           matrix_row3,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [COORD_W-1:0]  world_min_x,
  output logic signed [COORD_W-1:0]  world_min_y,
  output logic signed [COORD_W-1:0]  world_min_z,
  output logic signed [COORD_W-1:0]  world_max_x,
  output logic signed [COORD_W-1:0]  world_max_y,
  output logic signed [COORD_W-1:0]  world_max_z,
  output logic                       w_zero
);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X, REG_MIN_Y, REG_MIN_Z, REG_MAX_X, REG_MAX_Y, REG_MAX_Z
  } reg_idx_t;

  logic signed [COORD_W-1:0] lo [NUM_AXES];
  logic signed [COORD_W-1:0] hi [NUM_AXES];

  logic                      adv;
  logic                      busy;
  logic [2:0]                k;
  logic [NUM_COLS-1:0][ROW_W-1:0] mat;
  logic                      take;

  logic signed [ENT_W-1:0]   ent [NUM_COLS][NUM_COLS];
  logic signed [COORD_W-1:0] corner [NUM_AXES];

  ctl_t                      ctl_p, ctl_1, ctl_2, ctl_3, ctl_d;
  logic signed [PROD_W-1:0]  prod [NUM_COLS][NUM_AXES];
  logic signed [ENT_W-1:0]   t3 [NUM_COLS];
  logic signed [ACC_W-1:0]   s1a [NUM_COLS];
  logic signed [ACC_W-1:0]   s1b [NUM_COLS];
  logic signed [ACC_W-1:0]   acc [NUM_COLS];
  logic [NUM_AXES-1:0][MAG_W-1:0] num;
  mag_t                      den;
  logic [NUM_AXES-1:0]       neg;
  logic [NUM_AXES-1:0][COORD_W-1:0] quo;

  logic signed [COORD_W-1:0] mn [NUM_AXES];
  logic signed [COORD_W-1:0] mx [NUM_AXES];
  logic                      wzacc;
  logic signed [COORD_W-1:0] mn_next [NUM_AXES];
  logic signed [COORD_W-1:0] mx_next [NUM_AXES];
  logic                      wz_next;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = busy && !(adv && k == 3'd7);
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        lo[a] <= '0;
        hi[a] <= '0;
      end
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_MIN_X: lo[0] <= cfg_data;
        REG_MIN_Y: lo[1] <= cfg_data;
        REG_MIN_Z: lo[2] <= cfg_data;
        REG_MAX_X: hi[0] <= cfg_data;
        REG_MAX_Y: hi[1] <= cfg_data;
        REG_MAX_Z: hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // corner sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (take) begin
      busy <= 1'b1;
      k    <= '0;
    end else if (adv && busy) begin
      k <= k + 3'd1;
      if (k == 3'd7) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) mat <= {matrix_row3, matrix_row2, matrix_row1, matrix_row0};
  end

  always_comb begin
    for (int r = 0; r < NUM_COLS; r++) begin
      for (int j = 0; j < NUM_COLS; j++) begin
        ent[r][j] = $signed(mat[r][ENT_W*j +: ENT_W]);
      end
    end
    for (int a = 0; a < NUM_AXES; a++) corner[a] = k[a] ? hi[a] : lo[a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p.valid <= 1'b0;
      ctl_1.valid <= 1'b0;
      ctl_2.valid <= 1'b0;
      ctl_3.valid <= 1'b0;
    end else if (adv) begin
      ctl_p <= '{valid: busy, first: k == 3'd0, last: k == 3'd7, wz: 1'b0};
      ctl_1 <= ctl_p;
      ctl_2 <= ctl_1;
      ctl_3 <= '{valid: ctl_2.valid, first: ctl_2.first, last: ctl_2.last,
                 wz: acc[3] == '0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NUM_COLS; j++) begin
        for (int a = 0; a < NUM_AXES; a++) prod[j][a] <= corner[a] * ent[a][j];
        t3[j]  <= ent[3][j];
        s1a[j] <= ACC_W'(prod[j][0]) + ACC_W'(prod[j][1]);
        s1b[j] <= ACC_W'(prod[j][2]) + ACC_W'($signed({t3[j], {FRAC_W{1'b0}}}));
        acc[j] <= s1a[j] + s1b[j];
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        num[a] <= MAG_W'(acc[a][ACC_W-1] ? -acc[a] : acc[a]);
        neg[a] <= acc[a][ACC_W-1] ^ acc[3][ACC_W-1];
      end
      den <= MAG_W'(acc[3][ACC_W-1] ? -acc[3] : acc[3]);
    end
  end

  wabox_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_in  (ctl_3),
    .num_in  (num),
    .den_in  (den),
    .neg_in  (neg),
    .ctl_out (ctl_d),
    .quo_out (quo)
  );

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (ctl_d.first) begin
        mn_next[a] = $signed(quo[a]);
        mx_next[a] = $signed(quo[a]);
      end else begin
        mn_next[a] = ($signed(quo[a]) < mn[a]) ? $signed(quo[a]) : mn[a];
        mx_next[a] = ($signed(quo[a]) > mx[a]) ? $signed(quo[a]) : mx[a];
      end
    end
    wz_next = ctl_d.wz || (!ctl_d.first && wzacc);
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_d.valid) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        mn[a] <= mn_next[a];
        mx[a] <= mx_next[a];
      end
      wzacc <= wz_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= ctl_d.valid && ctl_d.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_d.valid && ctl_d.last) begin
      world_min_x <= wz_next ? '0 : mn_next[0];
      world_min_y <= wz_next ? '0 : mn_next[1];
      world_min_z <= wz_next ? '0 : mn_next[2];
      world_max_x <= wz_next ? '0 : mx_next[0];
      world_max_y <= wz_next ? '0 : mx_next[1];
      world_max_z <= wz_next ? '0 : mx_next[2];
      w_zero      <= wz_next;
    end
  end

  `WABOX_ASSERT_NXT(a_take_busy, clk, rst, take, busy)
  `WABOX_ASSERT_NXT(a_seq_hold, clk, rst, busy && !adv && !take, $stable(k))
  `WABOX_ASSERT_IMP(a_wz_zero, clk, rst, result_valid && w_zero, world_min_x == 0 && world_max_x == 0 && world_min_z == 0)
  `WABOX_ASSERT_IMP(a_order, clk, rst, result_valid && !w_zero, world_min_x <= world_max_x && world_min_y <= world_max_y && world_min_z <= world_max_z)

endmodule

// ----- rtl/core/wabox_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wabox_div
// Three-lane pipelined restoring divider, one quotient bit per stage,
// Q16.16 result with saturation. Lanes share the divisor.
// ---------------------------------------------------------------------------
module wabox_div import wabox_pkg::*; (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  ctl_t                                ctl_in,
  input  logic [NUM_AXES-1:0][MAG_W-1:0]      num_in,
  input  mag_t                                den_in,
  input  logic [NUM_AXES-1:0]                 neg_in,
  output ctl_t                                ctl_out,
  output logic [NUM_AXES-1:0][COORD_W-1:0]    quo_out
);

  ctl_t                             ctl_s [0:DIV_STEPS];
  mag_t                             den_s [0:DIV_STEPS];
  logic [NUM_AXES-1:0][MAG_W-1:0]   rem_s [0:DIV_STEPS];
  logic [NUM_AXES-1:0][QUO_W-1:0]   quo_s [0:DIV_STEPS];
  logic [NUM_AXES-1:0][QUO_W-1:0]   nb_s  [0:DIV_STEPS];
  logic [NUM_AXES-1:0]              neg_s [0:DIV_STEPS];
  logic [NUM_AXES-1:0]              ovf_s [0:DIV_STEPS];

  logic [NUM_AXES-1:0][MAG_W:0]     sh    [1:DIV_STEPS];
  logic [NUM_AXES-1:0][MAG_W:0]     diff  [1:DIV_STEPS];
  logic [NUM_AXES-1:0]              ge    [1:DIV_STEPS];

  always_comb begin
    for (int s = 1; s <= DIV_STEPS; s++) begin
      for (int l = 0; l < NUM_AXES; l++) begin
        sh[s][l]   = {rem_s[s-1][l], nb_s[s-1][l][QUO_W-1]};
        diff[s][l] = sh[s][l] - {1'b0, den_s[s-1]};
        ge[s][l]   = sh[s][l] >= {1'b0, den_s[s-1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_STEPS; s++) ctl_s[s].valid <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else if (adv) begin
      ctl_s[0] <= ctl_in;
      for (int s = 1; s <= DIV_STEPS; s++) ctl_s[s] <= ctl_s[s-1];
      ctl_out <= ctl_s[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_s[0] <= den_in;
      neg_s[0] <= neg_in;
      for (int l = 0; l < NUM_AXES; l++) begin
        rem_s[0][l] <= num_in[l] >> PRE_SHIFT;
        nb_s[0][l]  <= {num_in[l][PRE_SHIFT-1:0], {FRAC_W{1'b0}}};
        quo_s[0][l] <= '0;
        // quotient of 2^31 or more saturates
        ovf_s[0][l] <= {{PRE_SHIFT{1'b0}}, num_in[l]} >= {den_in, {PRE_SHIFT{1'b0}}};
      end
      for (int s = 1; s <= DIV_STEPS; s++) begin
        den_s[s] <= den_s[s-1];
        neg_s[s] <= neg_s[s-1];
        ovf_s[s] <= ovf_s[s-1];
        for (int l = 0; l < NUM_AXES; l++) begin
          rem_s[s][l] <= ge[s][l] ? diff[s][l][MAG_W-1:0] : sh[s][l][MAG_W-1:0];
          quo_s[s][l] <= {quo_s[s-1][l][QUO_W-2:0], ge[s][l]};
          nb_s[s][l]  <= {nb_s[s-1][l][QUO_W-2:0], 1'b0};
        end
      end
      for (int l = 0; l < NUM_AXES; l++) begin
        if (ovf_s[DIV_STEPS][l]) begin
          quo_out[l] <= neg_s[DIV_STEPS][l] ? {1'b1, {(COORD_W-1){1'b0}}}
                                            : {1'b0, {(COORD_W-1){1'b1}}};
        end else if (neg_s[DIV_STEPS][l]) begin
          quo_out[l] <= -{1'b0, quo_s[DIV_STEPS][l]};
        end else begin
          quo_out[l] <= {1'b0, quo_s[DIV_STEPS][l]};
        end
      end
    end
  end

endmodule
